### design/imu_motion_state_classifier_top_defines.svh
// Assertion macros for the IMU motion state classifier checker.
// No dependencies; included by the checker file.
`ifndef IMU_MOTION_STATE_CLASSIFIER_TOP_DEFINES_SVH
`define IMU_MOTION_STATE_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define IMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imc same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define IMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imc next-cycle check failed");

`endif

### design/imc_pkg.sv
// Shared types and constants of the IMU motion state classifier.
// No dependencies; imported by all modules of the block.
package imc_pkg;

   localparam int SAMPLE_W = 16;   // raw sensor sample
   localparam int SQ_W     = 31;   // square of one sample
   localparam int SUM_W    = 32;   // sum of three squares
   localparam int CSR_W    = 16;   // widest configuration register
   localparam int IDX_W    = 3;    // configuration register index

   // Motion state codes
   typedef enum logic [1:0] {
      ST_STATIONARY = 2'd0,
      ST_TILTED     = 2'd1,
      ST_ROTATING   = 2'd2,
      ST_MOVING     = 2'd3
   } motion_type;

   // Configuration register indexes
   localparam logic [IDX_W-1:0] REG_ONE_G_LEVEL       = 3'd0;
   localparam logic [IDX_W-1:0] REG_ACCEL_STILL_BAND  = 3'd1;
   localparam logic [IDX_W-1:0] REG_ACCEL_MOVE_BAND   = 3'd2;
   localparam logic [IDX_W-1:0] REG_GYRO_STILL_LIMIT  = 3'd3;
   localparam logic [IDX_W-1:0] REG_GYRO_ROTATE_LIMIT = 3'd4;
   localparam logic [IDX_W-1:0] REG_LEVEL_BAND        = 3'd5;
   localparam logic [IDX_W-1:0] REG_TILT_LIMIT        = 3'd6;

   // Reset values of the configuration registers
   localparam logic [14:0] RST_ONE_G_LEVEL       = 15'd16384;
   localparam logic [14:0] RST_ACCEL_STILL_BAND  = 15'd2006;
   localparam logic [14:0] RST_ACCEL_MOVE_BAND   = 15'd4180;
   localparam logic [15:0] RST_GYRO_STILL_LIMIT  = 16'd1965;
   localparam logic [15:0] RST_GYRO_ROTATE_LIMIT = 16'd3930;
   localparam logic [14:0] RST_LEVEL_BAND        = 15'd1638;
   localparam logic [14:0] RST_TILT_LIMIT        = 15'd3277;

   // Configuration as seen by the classifier
   typedef struct packed {
      logic [14:0] one_g_level;
      logic [14:0] accel_still_band;
      logic [14:0] accel_move_band;
      logic [15:0] gyro_still_limit;
      logic [15:0] gyro_rotate_limit;
      logic [14:0] level_band;
      logic [14:0] tilt_limit;
   } cfg_type;

endpackage

### design/imc_front.sv
// Front end: accepts a request, squares samples and limits, classifies the motion.
// Depends on imc_pkg; feeds imc_queue.
module imc_front import imc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   input  logic signed [SAMPLE_W-1:0] req_gyro_x,
   input  logic signed [SAMPLE_W-1:0] req_gyro_y,
   input  logic signed [SAMPLE_W-1:0] req_gyro_z,
   output logic                       push_valid,
   output motion_type                 push_state,
   input  logic                       push_ready
);

   function automatic logic [SQ_W-1:0] square16(input logic signed [SAMPLE_W-1:0] v);
      logic signed [2*SAMPLE_W-1:0] p;
      p = v * v;
      return p[SQ_W-1:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] abs16(input logic signed [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] n;
      n = ~v + 1'b1;
      return v[SAMPLE_W-1] ? n : v;
   endfunction

   // Stage 1 combinational terms
   logic [15:0]        hi_still, hi_move;
   logic signed [15:0] lo_still, lo_move;
   logic signed [17:0] az_dev;
   logic [16:0]        az_dev_abs;
   logic               level_in;

   // Stage 1 registers
   logic               s1_valid_ff;
   logic [SQ_W-1:0]    ax2_ff, ay2_ff, az2_ff, gx2_ff, gy2_ff, gz2_ff;
   logic [31:0]        hs2_ff, hm2_ff, gs2_ff, gr2_ff;
   logic [29:0]        ls2_ff, lm2_ff, t2_ff;
   logic               still_lo_neg_ff, move_lo_neg_ff, level_ff;

   // Stage 2 sums
   logic [SUM_W-1:0]   a2, h2, g2;
   logic               still;

   // Advance stage 1 whenever it is empty or drains into the queue
   assign req_ready  = !s1_valid_ff || push_ready;
   assign push_valid = s1_valid_ff;

   // Build the limits from the configuration
   always_comb begin
      hi_still   = {1'b0, cfg.one_g_level} + {1'b0, cfg.accel_still_band};
      hi_move    = {1'b0, cfg.one_g_level} + {1'b0, cfg.accel_move_band};
      lo_still   = $signed({1'b0, cfg.one_g_level}) - $signed({1'b0, cfg.accel_still_band});
      lo_move    = $signed({1'b0, cfg.one_g_level}) - $signed({1'b0, cfg.accel_move_band});
      az_dev     = {{2{req_accel_z[SAMPLE_W-1]}}, req_accel_z} - {3'b000, cfg.one_g_level};
      az_dev_abs = az_dev[17] ? 17'(-az_dev) : az_dev[16:0];
      level_in   = (abs16(req_accel_x) < {1'b0, cfg.level_band}) &&
                   (abs16(req_accel_y) < {1'b0, cfg.level_band}) &&
                   (az_dev_abs < {2'b00, cfg.level_band});
   end

   // Stage 1 valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Stage 1 payload: squares of samples and limits
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ax2_ff          <= square16(req_accel_x);
         ay2_ff          <= square16(req_accel_y);
         az2_ff          <= square16(req_accel_z);
         gx2_ff          <= square16(req_gyro_x);
         gy2_ff          <= square16(req_gyro_y);
         gz2_ff          <= square16(req_gyro_z);
         hs2_ff          <= hi_still * hi_still;
         hm2_ff          <= hi_move * hi_move;
         ls2_ff          <= lo_still[14:0] * lo_still[14:0];
         lm2_ff          <= lo_move[14:0] * lo_move[14:0];
         still_lo_neg_ff <= lo_still[15];
         move_lo_neg_ff  <= lo_move[15];
         gs2_ff          <= cfg.gyro_still_limit * cfg.gyro_still_limit;
         gr2_ff          <= cfg.gyro_rotate_limit * cfg.gyro_rotate_limit;
         t2_ff           <= cfg.tilt_limit * cfg.tilt_limit;
         level_ff        <= level_in;
      end
   end

   // Stage 2: sum squares and classify
   always_comb begin
      h2    = {1'b0, ax2_ff} + {1'b0, ay2_ff};
      a2    = h2 + {1'b0, az2_ff};
      g2    = {1'b0, gx2_ff} + {1'b0, gy2_ff} + {1'b0, gz2_ff};
      still = (a2 < hs2_ff) && (still_lo_neg_ff || (a2 > {2'b00, ls2_ff})) &&
              (g2 < gs2_ff);
      if (still) begin
         if (level_ff) begin
            push_state = ST_STATIONARY;
         end else if (h2 > {2'b00, t2_ff}) begin
            push_state = ST_TILTED;
         end else begin
            push_state = ST_STATIONARY;
         end
      end else if (g2 > gr2_ff) begin
         push_state = ST_ROTATING;
      end else if ((a2 > hm2_ff) || (!move_lo_neg_ff && (a2 < {2'b00, lm2_ff}))) begin
         push_state = ST_MOVING;
      end else begin
         push_state = ST_STATIONARY;
      end
   end

endmodule

### design/imc_queue.sv
// Short queue of classified states between the front and back ends.
// Depends on imc_pkg.
module imc_queue import imc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  motion_type push_state,
   output logic       push_ready,
   output logic       pop_valid,
   output motion_type pop_state,
   input  logic       pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   motion_type       slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_state  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed state
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_state;
      end
   end

endmodule

### design/imc_back.sv
// Back end: drops unchanged states and holds the response with its LED colour.
// Depends on imc_pkg; drains imc_queue.
module imc_back import imc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   input  motion_type pop_state,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_motion_state,
   output logic       rsp_led_red,
   output logic       rsp_led_green,
   output logic       rsp_led_blue
);

   motion_type last_state_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   motion_type rsp_state_ff;
   logic       changed, out_free, load;

   // Pop when the state is unchanged (drop) or the output slot is free
   assign changed  = (pop_state != last_state_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = pop_valid && (!changed || out_free);
   assign load     = pop && changed;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         last_state_ff <= ST_STATIONARY;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            last_state_ff <= pop_state;
         end
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_state_ff <= pop_state;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motion_state = rsp_state_ff;
   assign rsp_led_red      = (rsp_state_ff == ST_TILTED);
   assign rsp_led_green    = (rsp_state_ff == ST_MOVING);
   assign rsp_led_blue     = (rsp_state_ff == ST_ROTATING);

endmodule

### design/imu_motion_state_classifier_top.sv
// IMU motion state classifier, top level with configuration registers.
// Depends on imc_pkg, imc_front, imc_queue and imc_back.
//
// Usage:
//   req_* carries one six-axis sample (signed accel and gyro counts) with
//   valid/ready. rsp_* carries the new motion state and LED colour, and is
//   produced only when the classified state differs from the previous one.
//   csr_* writes one configuration register per cycle by index; write only
//   while no request is in flight. Indexes past the register list are ignored.
// Timing:
//   A request that changes the state passes the square stage, a queue slot
//   and the response register before it shows on rsp_valid. One request is
//   accepted per cycle while req_ready is high; the front pipeline and the
//   response register each handle one item a cycle while rsp_ready is high.
// Reset and stall:
//   Synchronous reset loads the register defaults, empties the pipeline and
//   queue, and sets the last state to stationary. While rsp_ready is low the
//   response holds; unchanged states still drain, and the queue and square
//   stage take QUEUE_DEPTH + 1 more requests before req_ready drops.
module imu_motion_state_classifier_top import imc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [IDX_W-1:0]           csr_index,
   input  logic [CSR_W-1:0]           csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   input  logic signed [SAMPLE_W-1:0] req_gyro_x,
   input  logic signed [SAMPLE_W-1:0] req_gyro_y,
   input  logic signed [SAMPLE_W-1:0] req_gyro_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_motion_state,
   output logic                       rsp_led_red,
   output logic                       rsp_led_green,
   output logic                       rsp_led_blue
);

   cfg_type    cfg_ff;
   logic       push_valid, push_ready, pop_valid, pop;
   motion_type push_state, pop_state;

   // Decode configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_g_level       <= RST_ONE_G_LEVEL;
         cfg_ff.accel_still_band  <= RST_ACCEL_STILL_BAND;
         cfg_ff.accel_move_band   <= RST_ACCEL_MOVE_BAND;
         cfg_ff.gyro_still_limit  <= RST_GYRO_STILL_LIMIT;
         cfg_ff.gyro_rotate_limit <= RST_GYRO_ROTATE_LIMIT;
         cfg_ff.level_band        <= RST_LEVEL_BAND;
         cfg_ff.tilt_limit        <= RST_TILT_LIMIT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ONE_G_LEVEL:       cfg_ff.one_g_level       <= csr_data[14:0];
            REG_ACCEL_STILL_BAND:  cfg_ff.accel_still_band  <= csr_data[14:0];
            REG_ACCEL_MOVE_BAND:   cfg_ff.accel_move_band   <= csr_data[14:0];
            REG_GYRO_STILL_LIMIT:  cfg_ff.gyro_still_limit  <= csr_data;
            REG_GYRO_ROTATE_LIMIT: cfg_ff.gyro_rotate_limit <= csr_data;
            REG_LEVEL_BAND:        cfg_ff.level_band        <= csr_data[14:0];
            REG_TILT_LIMIT:        cfg_ff.tilt_limit        <= csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   imc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .req_gyro_x  (req_gyro_x),
      .req_gyro_y  (req_gyro_y),
      .req_gyro_z  (req_gyro_z),
      .push_valid  (push_valid),
      .push_state  (push_state),
      .push_ready  (push_ready)
   );

   imc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_state (push_state),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_state  (pop_state),
      .pop        (pop)
   );

   imc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_state        (pop_state),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_motion_state (rsp_motion_state),
      .rsp_led_red      (rsp_led_red),
      .rsp_led_green    (rsp_led_green),
      .rsp_led_blue     (rsp_led_blue)
   );

endmodule

### design/imc_checker.sv
// Port-level checks for the IMU motion state classifier, bound to the top level.
// Depends on imc_pkg and imu_motion_state_classifier_top_defines.svh.
`include "imu_motion_state_classifier_top_defines.svh"

module imc_checker import imc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_motion_state,
   input logic       rsp_led_red,
   input logic       rsp_led_green,
   input logic       rsp_led_blue
);

   logic [1:0] last_sent_ff;

   // Track the last state delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sent_ff <= ST_STATIONARY;
      end else if (rsp_valid && rsp_ready) begin
         last_sent_ff <= rsp_motion_state;
      end
   end

   `IMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_motion_state) && $stable(rsp_led_red) && $stable(rsp_led_green) && $stable(rsp_led_blue))
   `IMC_ASSERT_IMPLY(a_led_match, clock, reset, rsp_valid, (rsp_led_red == (rsp_motion_state == ST_TILTED)) && (rsp_led_green == (rsp_motion_state == ST_MOVING)) && (rsp_led_blue == (rsp_motion_state == ST_ROTATING)))
   `IMC_ASSERT_IMPLY(a_state_changes, clock, reset, rsp_valid, rsp_motion_state != last_sent_ff)
   `IMC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind imu_motion_state_classifier_top imc_checker u_checker (.*);
